FILE: sv/gdn_pkg.sv
package gdn_pkg;

    // channel vector size and derived widths
    localparam int CHANNELS    = 16;
    localparam int CH_W        = $clog2(CHANNELS);
    localparam int CNT_W       = CH_W + 1;
    localparam int GAMMA_DEPTH = CHANNELS * CHANNELS;
    localparam int GAMMA_AW    = $clog2(GAMMA_DEPTH);

    // word commands
    localparam logic [1:0] CMD_BETA   = 2'd0;
    localparam logic [1:0] CMD_GAMMA  = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    // register indexes
    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    // one channel's state, held in a ring cell
    typedef struct packed {
        logic signed [63:0] acc;
        logic signed [31:0] beta;
        logic signed [31:0] x;
    } cell_t;

    // 64-bit add clamped to the signed range
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63])
            return {1'b0, {63{1'b1}}};
        if (a[63] && b[63] && !s[63])
            return {1'b1, {63{1'b0}}};
        return s;
    endfunction

    // apply sign to a magnitude, clamp to 32-bit signed
    function automatic logic [31:0] sat32(input logic [33:0] mag, input logic neg);
        if (neg)
        begin
            if (mag >= 34'h080000000)
                return 32'h80000000;
            return ~mag[31:0] + 32'd1;
        end
        if (mag > 34'h07FFFFFFF)
            return 32'h7FFFFFFF;
        return mag[31:0];
    endfunction

endpackage

FILE: sv/gdn_cell.sv
module gdn_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  gdn_pkg::cell_t prev,
    input  logic           beta_we,
    input  logic           x_we,
    input  logic [31:0]    wdata,
    output gdn_pkg::cell_t q
);
    import gdn_pkg::*;

    logic signed [63:0] acc_reg;
    logic signed [31:0] beta_reg;
    logic signed [31:0] x_reg;

    // accumulator: takes the neighbour's value on a shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (shift)
            acc_reg <= prev.acc;
    end

    // beta and sample: shift with the ring, or local write when idle
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            beta_reg <= prev.beta;
            x_reg    <= prev.x;
        end
        else
        begin
            if (beta_we)
                beta_reg <= wdata;
            if (x_we)
                x_reg <= wdata;
        end
    end

    assign q = '{acc: acc_reg, beta: beta_reg, x: x_reg};

endmodule

FILE: sv/gdn_norm.sv
module gdn_norm (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           mode,
    input  gdn_pkg::cell_t din,
    output logic           done,
    output logic [31:0]    y
);
    import gdn_pkg::*;

    localparam logic [2:0] N_IDLE   = 3'd0;
    localparam logic [2:0] N_DEN    = 3'd1;
    localparam logic [2:0] N_SEL    = 3'd2;
    localparam logic [2:0] N_DIV    = 3'd3;
    localparam logic [2:0] N_MUL_HI = 3'd4;
    localparam logic [2:0] N_MUL_LO = 3'd5;
    localparam logic [2:0] N_FIN    = 3'd6;

    logic [2:0]         state_reg;
    logic               done_reg;
    logic [31:0]        y_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] beta_reg;
    logic [31:0]        ax_reg;
    logic               negx_reg;
    logic signed [63:0] d_reg;
    logic [63:0]        ad_reg;
    logic [64:0]        r_reg;
    logic [30:0]        q_reg;
    logic [4:0]         step_reg;
    logic [63:0]        hi_reg;
    logic [31:0]        lo_reg;

    logic signed [31:0] beta_min;
    logic signed [63:0] d_calc;
    logic [64:0]        r_shift;
    logic               r_ge;
    logic [30:0]        q_next;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic [33:0]        inv_mag;

    // denominator: beta raised to one LSB, moved to Q32.32
    assign beta_min = (beta_reg < 32'sd1) ? 32'sd1 : beta_reg;
    assign d_calc   = sat_add64(acc_reg, {{16{beta_min[31]}}, beta_min, 16'd0});

    // one restoring division step
    assign r_shift = {r_reg[63:0], 1'b0};
    assign r_ge    = r_shift >= {1'b0, d_reg};
    assign q_next  = {q_reg[29:0], r_ge};

    // shared multiplier for the two halves of |D|
    assign mul_b   = (state_reg == N_MUL_HI) ? ad_reg[63:32] : ad_reg[31:0];
    assign mul_p   = {32'd0, ax_reg} * {32'd0, mul_b};
    assign inv_mag = (hi_reg > 64'h80000000) ? 34'h100000000
                   : hi_reg[33:0] + {2'd0, lo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        acc_reg   <= din.acc;
                        beta_reg  <= din.beta;
                        ax_reg    <= din.x[31] ? ~din.x + 32'd1 : din.x;
                        negx_reg  <= din.x[31];
                        done_reg  <= 1'b0;
                        state_reg <= N_DEN;
                    end
                end
                N_DEN:
                begin
                    d_reg     <= d_calc;
                    ad_reg    <= d_calc[63] ? ~d_calc + 64'd1 : d_calc;
                    state_reg <= N_SEL;
                end
                N_SEL:
                begin
                    if (mode)
                        state_reg <= N_MUL_HI;
                    else if (d_reg[63] || d_reg == 64'sd0)
                    begin
                        // non-positive denominator: sign of x at full scale
                        if (ax_reg == 32'd0)
                            y_reg <= 32'd0;
                        else
                            y_reg <= negx_reg ? 32'h80000000 : 32'h7FFFFFFF;
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end
                    else if ({31'd0, ax_reg, 1'b0} >= d_reg)
                    begin
                        // quotient at or above 2^31
                        y_reg     <= sat32(34'h080000000, negx_reg);
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end
                    else
                    begin
                        r_reg     <= {32'd0, ax_reg, 1'b0};
                        q_reg     <= '0;
                        step_reg  <= '0;
                        state_reg <= N_DIV;
                    end
                end
                N_DIV:
                begin
                    r_reg    <= r_ge ? r_shift - {1'b0, d_reg} : r_shift;
                    q_reg    <= q_next;
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd30)
                    begin
                        y_reg     <= sat32({3'd0, q_next}, negx_reg);
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end
                end
                N_MUL_HI:
                begin
                    hi_reg    <= mul_p;
                    state_reg <= N_MUL_LO;
                end
                N_MUL_LO:
                begin
                    lo_reg    <= mul_p[63:32];
                    state_reg <= N_FIN;
                end
                N_FIN:
                begin
                    y_reg     <= sat32(inv_mag, negx_reg ^ d_reg[63]);
                    done_reg  <= 1'b1;
                    state_reg <= N_IDLE;
                end
                default:
                    state_reg <= N_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

FILE: sv/divisive_normalization_gdn.sv
// Divisive normalization over a pixel vector of up to 16 channels.
// Input channel (in_valid/in_ready): words carry a command, an index, a Q16.16
// value and an end of image marker. Beta and gamma loads leave in_ready high.
// A sample holds in_ready low while the 16 denominator accumulators, in a ring of
// cells that turns once per sample, take one multiply-accumulate per cell as it
// passes the tail, fed from the gamma memory through a two stage pipeline.
// The sample of channel n-1 closes the pixel: the ring turns again, and each
// channel in use passes through the normaliser, multiplying (mode 1) or
// dividing (mode 0, one quotient bit a cycle). Results leave through a registered
// output (out_valid/out_ready), in channel order, the last flagged last_of_pixel.
// A stalled receiver holds the result and the close pauses behind it.
// in_ready is high only while no word is in progress.
// Configuration writes (cfg_we) apply at once; write them only when idle.
// Reset clears the accumulators, the image end flag, mode to forward and
// channel_count to 16; beta, gamma and sample stores are undefined until loaded.
module divisive_normalization_gdn (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [7:0]  index,
    input  logic [31:0] value,
    input  logic        end_of_image,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_value,
    output logic [3:0]  channel,
    output logic        last_of_pixel,
    output logic        end_of_image_out,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);
    import gdn_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_CHK  = 2'd2;
    localparam logic [1:0] ST_WAIT = 2'd3;

    logic [1:0]          state_reg;
    logic                mode_reg;
    logic [4:0]          count_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CH_W-1:0]     idx_reg;
    logic [31:0]         ax_reg;
    logic [GAMMA_AW-1:0] base_reg;
    logic                eoi_reg;
    logic [31:0]         g_reg;
    logic                gv_reg;
    logic signed [63:0]  prod_reg;
    logic                pv_reg;
    logic                out_valid_reg;
    logic [31:0]         out_value_reg;
    logic [CH_W-1:0]     out_ch_reg;
    logic                out_last_reg;
    logic                out_eoi_reg;

    logic [31:0]         gamma_mem [GAMMA_DEPTH];

    logic [CNT_W-1:0]    n_eff;
    logic                in_acc;
    logic                take;
    logic                norm_start;
    logic                norm_done;
    logic [31:0]         norm_y;
    logic                shift;
    logic signed [63:0]  tail_acc;
    logic signed [64:0]  prod_full;
    logic [CHANNELS-1:0] beta_we;
    logic [CHANNELS-1:0] x_we;
    cell_t               cell_q [CHANNELS];
    cell_t               tail;

    // effective channel count, clamped to 1..CHANNELS
    always_comb
    begin
        if (count_reg == 5'd0)
            n_eff = CNT_W'(1);
        else if (CNT_W'(count_reg) > CNT_W'(CHANNELS))
            n_eff = CNT_W'(CHANNELS);
        else
            n_eff = CNT_W'(count_reg);
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            count_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[0];
                CFG_COUNT: count_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // gamma memory: write on load, registered read during accumulation
    always_ff @(posedge clk)
    begin
        if (in_acc && command == CMD_GAMMA)
            gamma_mem[index] <= value;
        g_reg <= gamma_mem[base_reg + GAMMA_AW'(cnt_reg[CH_W-1:0])];
    end

    // product of gamma and |x|
    assign prod_full = $signed(g_reg) * $signed({1'b0, ax_reg});

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[63:0];
    end

    // cell write enables, decoded by index while idle
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            beta_we[c] = in_acc && command == CMD_BETA && index == 8'(c);
            x_we[c]    = in_acc && command == CMD_SAMPLE && index == 8'(c)
                         && index < 8'(n_eff);
        end
    end

    // ring control and the value entering the tail cell
    always_comb
    begin
        shift    = 1'b0;
        tail_acc = cell_q[0].acc;
        case (state_reg)
            ST_ACC:
            begin
                shift    = (cnt_reg >= CNT_W'(2)) && (cnt_reg <= CNT_W'(CHANNELS + 1));
                tail_acc = sat_add64(cell_q[0].acc, pv_reg ? prod_reg : 64'sd0);
            end
            ST_CHK:
            begin
                shift = 1'b1;
                if (cnt_reg < n_eff)
                    tail_acc = '0;
            end
            default:
                shift = 1'b0;
        endcase
    end

    assign tail       = '{acc: tail_acc, beta: cell_q[0].beta, x: cell_q[0].x};
    assign norm_start = (state_reg == ST_CHK) && (cnt_reg < n_eff);
    assign take       = (state_reg == ST_WAIT) && norm_done && !norm_start
                        && (!out_valid_reg || out_ready);

    // ring of channel cells
    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_ring
        gdn_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (shift),
            .prev    ((c == CHANNELS - 1) ? tail : cell_q[(c + 1) % CHANNELS]),
            .beta_we (beta_we[c]),
            .x_we    (x_we[c]),
            .wdata   (value),
            .q       (cell_q[c])
        );
    end

    gdn_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .mode  (mode_reg),
        .din   (cell_q[0]),
        .done  (norm_done),
        .y     (norm_y)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            eoi_reg   <= 1'b0;
            gv_reg    <= 1'b0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            gv_reg <= (state_reg == ST_ACC) && (cnt_reg < n_eff);
            pv_reg <= gv_reg;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && command == CMD_SAMPLE && index < 8'(n_eff))
                    begin
                        idx_reg   <= index[CH_W-1:0];
                        ax_reg    <= value[31] ? ~value + 32'd1 : value;
                        base_reg  <= GAMMA_AW'(GAMMA_AW'(index[CH_W-1:0])
                                     * GAMMA_AW'(n_eff));
                        eoi_reg   <= eoi_reg | end_of_image;
                        cnt_reg   <= '0;
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    if (cnt_reg == CNT_W'(CHANNELS + 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (CNT_W'(idx_reg) == n_eff - CNT_W'(1))
                                     ? ST_CHK : ST_IDLE;
                    end
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                ST_CHK:
                begin
                    if (cnt_reg < n_eff)
                        state_reg <= ST_WAIT;
                    else if (cnt_reg == CNT_W'(CHANNELS - 1))
                    begin
                        eoi_reg   <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                ST_WAIT:
                begin
                    if (take)
                    begin
                        if (cnt_reg == CNT_W'(CHANNELS - 1))
                        begin
                            eoi_reg   <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg + CNT_W'(1);
                            state_reg <= ST_CHK;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
        begin
            out_valid_reg <= 1'b1;
            out_value_reg <= norm_y;
            out_ch_reg    <= cnt_reg[CH_W-1:0];
            out_last_reg  <= (cnt_reg == n_eff - CNT_W'(1));
            out_eoi_reg   <= eoi_reg;
        end
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid        = out_valid_reg;
    assign result_value     = out_value_reg;
    assign channel          = out_ch_reg;
    assign last_of_pixel    = out_last_reg;
    assign end_of_image_out = out_eoi_reg;

endmodule

FILE: sv/gdn_checker.sv
module gdn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  command,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result_value,
    input logic [3:0]  channel,
    input logic        last_of_pixel
);
    import gdn_pkg::*;

    // a stalled result word holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value))
        else $error("result word changed while stalled");

    // a table load leaves in_ready high
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == CMD_BETA || command == CMD_GAMMA)
        |=> in_ready)
        else $error("load word did not return to idle");

    // the top channel is always the last of its pixel
    a_top_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && channel == 4'(CHANNELS - 1) |-> last_of_pixel)
        else $error("top channel not flagged last");

endmodule

bind divisive_normalization_gdn gdn_checker u_gdn_checker (.*);
